### rtl/core/dds_tone_player_top_defines.svh
// Assertion macros for the tone player checker.
`ifndef DDS_TONE_PLAYER_TOP_DEFINES_SVH
`define DDS_TONE_PLAYER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dtp_pkg.sv
// Shared types, constants and the sine table for the tone player.
`default_nettype none

package dtp_pkg;

   localparam int DefaultQueueDepth = 8;

   localparam int FreqBits   = 13;
   localparam int MsBits     = 16;
   localparam int SampleBits = 16;
   localparam int LevelBits  = 4;
   localparam int LenBits    = 21;
   localparam int PhaseBits  = 24;

   localparam int TablePoints = 256;
   localparam int TableBits   = $clog2(TablePoints);
   localparam int Amplitude   = 32000;
   localparam int RateHz      = 16000;
   localparam int MsPerSec    = 1000;
   localparam int SamplesPerMs = RateHz / MsPerSec;

   // Phase step floor(f * 2^24 / RateHz) = f * StepWhole + floor(f * StepRem / RateHz).
   // The fractional part uses a rounded-up reciprocal of RateHz folded with StepRem.
   localparam longint unsigned StepWhole   = (64'd1 << PhaseBits) / RateHz;
   localparam longint unsigned StepRem     = (64'd1 << PhaseBits) % RateHz;
   localparam int              RecipShift  = 41;
   localparam longint unsigned StepRecip   = ((64'd1 << RecipShift) + RateHz - 1) / RateHz;
   localparam longint unsigned StepFracMul = StepRem * StepRecip;
   localparam int              FracMulBits = $clog2(StepFracMul + 1);

   localparam longint unsigned HalfPiQ30 = 64'd1686629713;

   typedef enum logic [1:0] {
      CmdTick    = 2'd0,
      CmdEnqueue = 2'd1,
      CmdClear   = 2'd2
   } dtp_cmd_type;

   typedef enum logic [1:0] {
      KindNop,
      KindTick,
      KindEnqueue,
      KindClear
   } dtp_kind_type;

   typedef struct packed {
      logic                 playable;
      logic [PhaseBits-1:0] step;
      logic [LenBits-1:0]   len;
   } dtp_tone_type;

   typedef struct packed {
      dtp_kind_type kind;
      dtp_tone_type tone;
   } dtp_item_type;

   typedef logic signed [SampleBits-1:0] sine_table_type [TablePoints];

   // sin(x) for x in [0, pi/2], argument and result in unsigned Q30
   function automatic longint unsigned sin_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint          sum;
      int              k;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 7; k++) begin
         prod = (term * x2) >> 30;
         case (k)
            1:       term = prod / 6;
            2:       term = prod / 20;
            3:       term = prod / 42;
            4:       term = prod / 72;
            5:       term = prod / 110;
            6:       term = prod / 156;
            default: term = prod / 210;
         endcase
         if (k % 2 == 1) sum = sum - longint'(term);
         else            sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : longint'(sum);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type  tbl;
      int unsigned     quad;
      int unsigned     rem;
      int unsigned     part;
      longint unsigned x;
      longint unsigned mag;
      int              i;
      for (i = 0; i < TablePoints; i++) begin
         quad = (4 * i) / TablePoints;
         rem  = 4 * i - quad * TablePoints;
         part = (quad % 2 == 1) ? TablePoints - rem : rem;
         x    = (HalfPiQ30 * part) / TablePoints;
         mag  = (sin_q30(x) * Amplitude + (64'd1 << 19)) >> 30;
         if (mag > Amplitude) mag = Amplitude;
         tbl[i] = (quad >= 2) ? -$signed(SampleBits'(mag)) : $signed(SampleBits'(mag));
      end
      return tbl;
   endfunction

   localparam sine_table_type SineTable = build_sine_table();

endpackage

`default_nettype wire

### rtl/core/dtp_front.sv
// Front end: registers each item, decodes the command and precomputes tone setup.
`default_nettype none

module dtp_front import dtp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [FreqBits-1:0] req_tone_freq,
   input  logic [MsBits-1:0]   req_tone_ms,
   output logic                item_valid,
   output dtp_item_type        item_data,
   input  logic                item_ready
);

   localparam int ProdBits = FreqBits + FracMulBits;

   logic                valid_ff, valid_in;
   logic [1:0]          cmd_ff;
   logic [FreqBits-1:0] freq_ff;
   logic [MsBits-1:0]   ms_ff;
   logic [FreqBits-1:0] frac_ff, frac_in;
   logic [ProdBits-1:0] frac_prod;
   logic                advance;

   assign advance   = !valid_ff || item_ready;
   assign req_stall = !advance;

   // floor(f * StepRem / RateHz) by reciprocal multiply
   assign frac_prod = ProdBits'(req_tone_freq) * ProdBits'(StepFracMul);
   assign frac_in   = frac_prod[RecipShift +: FreqBits];

   assign valid_in = advance ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         cmd_ff  <= req_cmd;
         freq_ff <= req_tone_freq;
         ms_ff   <= req_tone_ms;
         frac_ff <= frac_in;
      end
   end

   always_comb begin
      case (cmd_ff)
         CmdTick:    item_data.kind = KindTick;
         CmdEnqueue: item_data.kind = KindEnqueue;
         CmdClear:   item_data.kind = KindClear;
         default:    item_data.kind = KindNop;
      endcase
      item_data.tone.step     = PhaseBits'(freq_ff) * PhaseBits'(StepWhole)
                                + PhaseBits'(frac_ff);
      item_data.tone.len      = LenBits'(ms_ff) * LenBits'(SamplesPerMs);
      item_data.tone.playable = (freq_ff != '0) && (ms_ff != '0);
   end

   assign item_valid = valid_ff;

endmodule

`default_nettype wire

### rtl/core/dtp_fifo.sv
// Small flop-based FIFO that decouples the front end from the back end.
`default_nettype none

module dtp_fifo import dtp_pkg::*; #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [Width-1:0] pop_data,
   input  logic             pop
);

   localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   logic [Width-1:0]     mem_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CountBits'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/dtp_back.sv
// Back end: tone command queue, phase accumulator, sine lookup and result register.
`default_nettype none

module dtp_back import dtp_pkg::*; #(
   parameter int QueueDepth = DefaultQueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic                         csr_write_data,
   input  logic                         item_valid,
   input  dtp_item_type                 item_data,
   output logic                         item_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SampleBits-1:0] rsp_sample,
   output logic                         rsp_sample_valid,
   output logic                         rsp_playing,
   output logic                         rsp_accepted,
   output logic [LevelBits-1:0]         rsp_queue_level
);

   localparam int PtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountBits = $clog2(QueueDepth + 1);

   function automatic logic [PtrBits-1:0] ptr_next(input logic [PtrBits-1:0] p);
      return (p == PtrBits'(QueueDepth - 1)) ? '0 : p + PtrBits'(1);
   endfunction

   dtp_tone_type         pend_ff [QueueDepth];
   logic                 enable_ff, enable_in;
   logic [PtrBits-1:0]   head_ff, head_in;
   logic [PtrBits-1:0]   tail_ff, tail_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 active_ff, active_in;
   logic [PhaseBits-1:0] phase_ff, phase_in;
   logic [PhaseBits-1:0] step_ff, step_in;
   logic [LenBits-1:0]   left_ff, left_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SampleBits-1:0] rsp_sample_ff, rsp_sample_in;
   logic                         rsp_sample_valid_ff, rsp_sample_valid_in;
   logic                         rsp_playing_ff, rsp_playing_in;
   logic                         rsp_accepted_ff, rsp_accepted_in;
   logic [LevelBits-1:0]         rsp_queue_level_ff, rsp_queue_level_in;

   logic                 fire;
   logic                 wr_en;
   logic                 take;
   logic                 start;
   logic                 sound;
   dtp_tone_type         head_tone;
   logic [PhaseBits-1:0] base_phase;
   logic [PhaseBits-1:0] cur_step;
   logic [LenBits-1:0]   cur_left;

   assign fire      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign item_pop  = fire;
   assign head_tone = pend_ff[head_ff];

   assign enable_in = csr_write_en ? csr_write_data : enable_ff;

   // A tick on an idle player takes the head tone; a playable one sounds on this tick while audio is enabled.
   assign take  = fire && (item_data.kind == KindTick) && !active_ff && (count_ff != '0);
   assign start = take && enable_ff && head_tone.playable;
   assign sound = fire && (item_data.kind == KindTick) && (active_ff || start);

   assign base_phase = start ? '0 : phase_ff;
   assign cur_step   = start ? head_tone.step : step_ff;
   assign cur_left   = start ? head_tone.len : left_ff;

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      rsp_accepted_in = 1'b0;
      if (fire) begin
         case (item_data.kind)
            KindEnqueue: begin
               if (enable_ff && (count_ff != CountBits'(QueueDepth))) begin
                  wr_en           = 1'b1;
                  tail_in         = ptr_next(tail_ff);
                  count_in        = count_ff + CountBits'(1);
                  rsp_accepted_in = 1'b1;
               end
            end
            KindClear: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            KindTick: begin
               if (take) begin
                  head_in  = ptr_next(head_ff);
                  count_in = count_ff - CountBits'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      left_in   = left_ff;
      if (sound) begin
         phase_in  = base_phase + cur_step;
         step_in   = cur_step;
         left_in   = cur_left - LenBits'(1);
         active_in = (cur_left != LenBits'(1));
      end
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_sample_in       = rsp_sample_ff;
      rsp_sample_valid_in = rsp_sample_valid_ff;
      rsp_playing_in      = rsp_playing_ff;
      rsp_queue_level_in  = rsp_queue_level_ff;
      if (fire) begin
         rsp_valid_in        = 1'b1;
         rsp_sample_in       = sound ? SineTable[base_phase[PhaseBits-1 -: TableBits]] : '0;
         rsp_sample_valid_in = sound;
         rsp_playing_in      = sound || active_in;
         rsp_queue_level_in  = LevelBits'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_ff[tail_ff] <= item_data.tone;
      end
   end

   // hold the result while it is stalled
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_accepted_ff <= rsp_accepted_in;
      end
      rsp_sample_ff       <= rsp_sample_in;
      rsp_sample_valid_ff <= rsp_sample_valid_in;
      rsp_playing_ff      <= rsp_playing_in;
      rsp_queue_level_ff  <= rsp_queue_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_sample_valid = rsp_sample_valid_ff;
   assign rsp_playing      = rsp_playing_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_queue_level  = rsp_queue_level_ff;

endmodule

`default_nettype wire

### rtl/core/dds_tone_player_top.sv
// Sine tone player top level: front end, decoupling FIFO and synthesis back end.
//
// The player takes one item per clock while req_stall is low and returns one result
// per item, in order. An item passes the front register (command decode and phase
// step setup), a two-entry FIFO and the back end, whose output register holds the
// result as the back end pops the item from the FIFO. The back end retires one item
// per cycle from the FIFO unless rsp_stall holds the output register; when it does,
// the FIFO absorbs two items and the front register a third before req_stall rises.
// Tone commands wait in a QueueDepth-entry queue; a sample tick on an idle player
// takes the head tone; if enabled, a playable one produces its first sample on that tick.
// The sine lookup is a constant 256-entry table indexed by the top phase bits.
// The audio enable register resets to 1 and should be written only while idle.
`default_nettype none

module dds_tone_player_top import dtp_pkg::*; #(
   parameter int QueueDepth = DefaultQueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [FreqBits-1:0]          req_tone_freq,
   input  logic [MsBits-1:0]            req_tone_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SampleBits-1:0] rsp_sample,
   output logic                         rsp_sample_valid,
   output logic                         rsp_playing,
   output logic                         rsp_accepted,
   output logic [LevelBits-1:0]         rsp_queue_level,
   input  logic                         csr_write_en,
   input  logic                         csr_write_data
);

   localparam int ItemBits = $bits(dtp_item_type);

   logic                front_valid;
   dtp_item_type        front_item;
   logic                fifo_ready;
   logic                fifo_valid;
   logic [ItemBits-1:0] fifo_data;
   dtp_item_type        back_item;
   logic                back_pop;

   dtp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_tone_freq (req_tone_freq),
      .req_tone_ms   (req_tone_ms),
      .item_valid    (front_valid),
      .item_data     (front_item),
      .item_ready    (fifo_ready)
   );

   dtp_fifo #(
      .Width (ItemBits),
      .Depth (2)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_data  (ItemBits'(front_item)),
      .push_ready (fifo_ready),
      .pop_valid  (fifo_valid),
      .pop_data   (fifo_data),
      .pop        (back_pop)
   );

   assign back_item = dtp_item_type'(fifo_data);

   dtp_back #(
      .QueueDepth (QueueDepth)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .item_valid       (fifo_valid),
      .item_data        (back_item),
      .item_pop         (back_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_playing      (rsp_playing),
      .rsp_accepted     (rsp_accepted),
      .rsp_queue_level  (rsp_queue_level)
   );

endmodule

`default_nettype wire

### rtl/core/dtp_checker.sv
// Port-level checker for the tone player, bound to the top level.
`default_nettype none
`include "dds_tone_player_top_defines.svh"

module dtp_checker import dtp_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [SampleBits-1:0] rsp_sample,
   input logic                         rsp_sample_valid,
   input logic                         rsp_playing,
   input logic                         rsp_accepted,
   input logic [LevelBits-1:0]         rsp_queue_level
);

   `DTP_ASSERT_NOW(a_sample_means_playing, clock, reset, rsp_valid && rsp_sample_valid, rsp_playing, "sample produced while not playing")

   `DTP_ASSERT_NOW(a_silent_is_zero, clock, reset, rsp_valid && !rsp_sample_valid, rsp_sample == '0, "nonzero sample without sample_valid")

   `DTP_ASSERT_NOW(a_enqueue_no_sample, clock, reset, rsp_valid && rsp_accepted, !rsp_sample_valid, "accepted enqueue also produced a sample")

   `DTP_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample) && $stable(rsp_queue_level), "stalled result changed")

endmodule

bind dds_tone_player_top dtp_checker u_dtp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample       (rsp_sample),
   .rsp_sample_valid (rsp_sample_valid),
   .rsp_playing      (rsp_playing),
   .rsp_accepted     (rsp_accepted),
   .rsp_queue_level  (rsp_queue_level)
);

`default_nettype wire
